[src/hps_pkg.sv]
`timescale 1ns / 1ps

package hps_pkg;

    // item modes
    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;

    // fixed result widths
    localparam int Q_FRAC = 16;
    localparam int HP_W   = 16;
    localparam int HR_W   = 17;

    // divider request
    typedef struct packed {
        logic start;
        logic wide;
    } div_ctrl_t;

endpackage

[src/hps_mem.sv]
`timescale 1ns / 1ps

module hps_mem #(
    parameter int DEPTH = 8,
    parameter int AW    = 3,
    parameter int W     = 16
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [W-1:0]  wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [W-1:0]  rdata
);

    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/hps_div.sv]
`timescale 1ns / 1ps

module hps_div #(
    parameter int PB = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  hps_pkg::div_ctrl_t    ctrl,
    input  logic [PB-1:0]         dividend,
    input  logic [PB-1:0]         divisor,
    output logic                  done,
    output logic [PB+hps_pkg::Q_FRAC-1:0] quot,
    output logic [PB-1:0]         rem
);

    localparam int DW = PB + hps_pkg::Q_FRAC;
    localparam int CNW = $clog2(DW + 1);

    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [CNW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]  dvd_reg, dvd_next;
    logic [DW-1:0]  quot_reg, quot_next;
    logic [PB-1:0]  rem_reg, rem_next;
    logic [PB-1:0]  dsr_reg, dsr_next;

    logic [PB:0] rem_sh;
    logic [PB:0] diff;

    // one restoring step per cycle, dividend fed msb first
    assign rem_sh = {rem_reg, dvd_reg[DW-1]};
    assign diff   = rem_sh - {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (ctrl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = ctrl.wide ? CNW'(DW) : CNW'(PB);
            dvd_next  = {dividend, {hps_pkg::Q_FRAC{1'b0}}};
            quot_next = '0;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[DW-2:0], 1'b0};
            if (!diff[PB])
            begin
                rem_next  = diff[PB-1:0];
                quot_next = {quot_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh[PB-1:0];
                quot_next = {quot_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNW'(1);
            if (cnt_reg == CNW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

[src/harmonic_period_search.sv]
`timescale 1ns / 1ps

// channel | beat moves                                          | handshake
// --------+-----------------------------------------------------+-------------------
// in      | mode, stored_period, resource_period, task_period   | in_valid / in_ready
// out     | found, harmonic_period, harmonicity, bad_period     | out_valid / out_ready
//
// clear and append beats finish in the cycle they are taken and give no result beat.
// a query with a zero resource period goes straight to the result; one with nothing to try
// ends after the first division; else each stored period is tested against each multiple
// tried on the shared bit-serial divider; a search that finds nothing skips the ratio division.
// reset clears the list count and the control; list entries stay undefined until written.
// a finished result waits in the output register; the next beat is taken meanwhile.

module harmonic_period_search #(
    parameter int MAX_STORED  = 8,
    parameter int PERIOD_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 mode,
    input  logic [PERIOD_BITS-1:0]     stored_period,
    input  logic [PERIOD_BITS-1:0]     resource_period,
    input  logic [PERIOD_BITS-1:0]     task_period,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       found,
    output logic [hps_pkg::HP_W-1:0]   harmonic_period,
    output logic [hps_pkg::HR_W-1:0]   harmonicity,
    output logic                       bad_period
);

    localparam int PB = PERIOD_BITS;
    localparam int DW = PB + hps_pkg::Q_FRAC;
    localparam int CW = $clog2(MAX_STORED + 1);
    localparam int AW = (MAX_STORED > 1) ? $clog2(MAX_STORED) : 1;
    localparam int HP_W = hps_pkg::HP_W;
    localparam int HR_W = hps_pkg::HR_W;

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;  // take a beat
    localparam logic [2:0] S_KDIV = 3'd1;  // task / resource
    localparam logic [2:0] S_RD   = 3'd2;  // read next stored period
    localparam logic [2:0] S_CHK  = 3'd3;  // pick larger / smaller
    localparam logic [2:0] S_MOD  = 3'd4;  // remainder test
    localparam logic [2:0] S_HDIV = 3'd5;  // ratio in q1.16
    localparam logic [2:0] S_DONE = 3'd6;  // hand result to output register

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [PB-1:0] rp_reg, rp_next;
    logic [PB-1:0] tp_reg, tp_next;
    logic [PB-1:0] cand_reg, cand_next;

    // pending result, built during the search
    logic            pfound_reg, pfound_next;
    logic [HP_W-1:0] php_reg, php_next;
    logic [HR_W-1:0] phr_reg, phr_next;
    logic            pbad_reg, pbad_next;

    // output register
    logic            ovalid_reg, ovalid_next;
    logic            ofound_reg, ofound_next;
    logic [HP_W-1:0] ohp_reg, ohp_next;
    logic [HR_W-1:0] ohr_reg, ohr_next;
    logic            obad_reg, obad_next;

    // list memory
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic          mem_re;
    logic [PB-1:0] mem_rdata;

    // divider
    hps_pkg::div_ctrl_t div_ctrl;
    logic [PB-1:0]      div_a;
    logic [PB-1:0]      div_b;
    logic               div_done;
    logic [DW-1:0]      div_quot;
    logic [PB-1:0]      div_rem;

    logic              in_take;
    logic [PB+HP_W-1:0] cand_ext;

    assign in_take  = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    // candidate truncated or zero-extended to the result width
    assign cand_ext = {{HP_W{1'b0}}, cand_reg};
    assign mem_waddr = count_reg[AW-1:0];

    hps_mem #(
        .DEPTH (MAX_STORED),
        .AW    (AW),
        .W     (PB)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (stored_period),
        .re    (mem_re),
        .raddr (idx_reg[AW-1:0]),
        .rdata (mem_rdata)
    );

    hps_div #(
        .PB (PB)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        rp_next     = rp_reg;
        tp_next     = tp_reg;
        cand_next   = cand_reg;
        pfound_next = pfound_reg;
        php_next    = php_reg;
        phr_next    = phr_reg;
        pbad_next   = pbad_reg;
        ovalid_next = ovalid_reg;
        ofound_next = ofound_reg;
        ohp_next    = ohp_reg;
        ohr_next    = ohr_reg;
        obad_next   = obad_reg;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        div_ctrl    = '0;
        div_a       = task_period;
        div_b       = resource_period;

        if (ovalid_reg && out_ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    case (mode)
                        hps_pkg::MODE_CLEAR:
                        begin
                            count_next = '0;
                        end
                        hps_pkg::MODE_APPEND:
                        begin
                            // zero periods and appends to a full list are dropped
                            if (stored_period != '0 && count_reg < CW'(MAX_STORED))
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        hps_pkg::MODE_QUERY:
                        begin
                            rp_next     = resource_period;
                            tp_next     = task_period;
                            pfound_next = 1'b0;
                            php_next    = '0;
                            phr_next    = '0;
                            pbad_next   = 1'b0;
                            if (resource_period == '0)
                            begin
                                // zero resource period: flag, no search
                                pbad_next  = 1'b1;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                div_ctrl.start = 1'b1;
                                state_next     = S_KDIV;
                            end
                        end
                        default:
                        begin
                            // unused mode: beat taken and ignored
                        end
                    endcase
                end
            end
            S_KDIV:
            begin
                if (div_done)
                begin
                    if (div_quot[PB-1:0] == '0)
                    begin
                        // task shorter than resource: nothing to try
                        state_next = S_DONE;
                    end
                    else
                    begin
                        // largest multiple not above the task
                        cand_next  = tp_reg - div_rem;
                        idx_next   = '0;
                        state_next = S_RD;
                    end
                end
            end
            S_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    // every stored period fits this multiple
                    div_ctrl.start = 1'b1;
                    div_ctrl.wide  = 1'b1;
                    div_a          = cand_reg;
                    div_b          = tp_reg;
                    state_next     = S_HDIV;
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                // only larger mod smaller can be zero
                div_ctrl.start = 1'b1;
                if (cand_reg >= mem_rdata)
                begin
                    div_a = cand_reg;
                    div_b = mem_rdata;
                end
                else
                begin
                    div_a = mem_rdata;
                    div_b = cand_reg;
                end
                state_next = S_MOD;
            end
            S_MOD:
            begin
                if (div_done)
                begin
                    if (div_rem == '0)
                    begin
                        idx_next   = idx_reg + CW'(1);
                        state_next = S_RD;
                    end
                    else if (cand_reg == rp_reg)
                    begin
                        // last multiple failed: none found
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cand_next  = cand_reg - rp_reg;
                        idx_next   = '0;
                        state_next = S_RD;
                    end
                end
            end
            S_HDIV:
            begin
                if (div_done)
                begin
                    pfound_next = 1'b1;
                    php_next    = cand_ext[HP_W-1:0];
                    phr_next    = div_quot[HR_W-1:0];
                    state_next  = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    ovalid_next = 1'b1;
                    ofound_next = pfound_reg;
                    ohp_next    = php_reg;
                    ohr_next    = phr_reg;
                    obad_next   = pbad_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        rp_reg     <= rp_next;
        tp_reg     <= tp_next;
        cand_reg   <= cand_next;
        pfound_reg <= pfound_next;
        php_reg    <= php_next;
        phr_reg    <= phr_next;
        pbad_reg   <= pbad_next;
        ofound_reg <= ofound_next;
        ohp_reg    <= ohp_next;
        ohr_reg    <= ohr_next;
        obad_reg   <= obad_next;
    end

    assign out_valid       = ovalid_reg;
    assign found           = ofound_reg;
    assign harmonic_period = ohp_reg;
    assign harmonicity     = ohr_reg;
    assign bad_period      = obad_reg;

`ifndef SYNTHESIS
    // list count stays within the memory depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_STORED))
        else $error("list count beyond depth");

    // divider finishes only while the sequencer waits on it
    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_KDIV || state_reg == S_MOD || state_reg == S_HDIV))
        else $error("divider done in wrong state");

    // a flagged period carries no answer
    a_bad_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && bad_period) |-> (!found && harmonic_period == '0 && harmonicity == '0))
        else $error("bad period result not cleared");

    // a found ratio lies in (0, 1.0]
    a_ratio_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && found) |-> (harmonicity != '0 && harmonicity <= HR_W'(65536)))
        else $error("harmonicity out of range");
`endif

endmodule
